/* rtl/tsdesc_pkg.sv */
// Package for the transport packet AES-128 ECB descrambler.
// Holds the S-box tables, AES round helpers, FSM type and register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsdesc_pkg;

  localparam int DEF_PACKET_BYTES = 188;
  localparam int CFG_INDEX_W      = 8;
  localparam int CFG_DATA_W       = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_EVEN_KEY_HIGH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EVEN_KEY_LOW  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ODD_KEY_HIGH  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ODD_KEY_LOW   = 8'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_EMIT
  } state_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // round constant used to derive round key r (r = 1..10)
  function automatic logic [7:0] rcon_of(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // SubWord(RotWord(w)) ^ rcon
  function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc);
    logic [31:0] r;
    r = {w[23:0], w[31:24]};
    return {FWD_SBOX[r[31:24]] ^ rc, FWD_SBOX[r[23:16]], FWD_SBOX[r[15:8]], FWD_SBOX[r[7:0]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[127:96] ^ key_core(k[31:0], rc);
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] key_back(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p1, p2, p3, p0;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ key_core(p3, rc);
    return {p0, p1, p2, p3};
  endfunction

  // byte k of a 128-bit block sits at bits 127-8k downto 120-8k
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    logic [1:0]   src_c;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src_c = 2'(c - r);
        t[127 - 8 * (r + 4 * c) -: 8] = INV_SBOX[s[127 - 8 * (r + 4 * int'(src_c)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   m9 [4];
    logic [7:0]   m11 [4];
    logic [7:0]   m13 [4];
    logic [7:0]   m14 [4];
    logic [7:0]   x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]   = s[127 - 8 * (4 * c + j) -: 8];
        x2     = xtime(a[j]);
        x4     = xtime(x2);
        x8     = xtime(x4);
        m9[j]  = x8 ^ a[j];
        m11[j] = x8 ^ x2 ^ a[j];
        m13[j] = x8 ^ x4 ^ a[j];
        m14[j] = x8 ^ x4 ^ x2;
      end
      t[127 - 8 * (4 * c)     -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[127 - 8 * (4 * c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[127 - 8 * (4 * c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* rtl/tsdesc_if.sv */
// Channel interfaces of the descrambler: packet bytes in, result bytes out,
// key register writes. Depends on tsdesc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tsdesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_start;
  modport source (output valid, output packet_byte, output packet_start, input ready);
  modport sink   (input valid, input packet_byte, input packet_start, output ready);
endinterface

interface tsdesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_last;
  modport source (output valid, output out_byte, output packet_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input packet_end, input run_last,
                  output ready);
endinterface

interface tsdesc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tsdesc_pkg::CFG_INDEX_W-1:0] index;
  logic [tsdesc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/ts_packet_aes128_ecb_descrambler.sv */
// Top level of the transport packet AES-128 ECB descrambler.
// Depends on tsdesc_pkg (tables, round helpers, FSM type) and tsdesc_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                  Moves on
// stream   in   packet_byte[7:0], packet_start           valid & ready
// result   out  out_byte[7:0], packet_end, run_last      valid & ready
// regs     in   index[7:0], data[63:0] (key halves)      valid & ready (ready tied high)
//
// A clear byte is registered for output; the next request is taken in the cycle its
// result is drained. The sixteenth byte of a scrambled block starts the shared
// round unit: forward key expansion up to round key 10, 11 inverse rounds (one per
// cycle, round key stepped backwards alongside), then output of the 16 clear bytes.
// stream.ready is low while the round unit is busy. rst is synchronous and
// clears position, flags and keys. Stalls on result simply hold the current
// byte; no request is lost.

module ts_packet_aes128_ecb_descrambler #(
  parameter int PACKET_BYTES = tsdesc_pkg::DEF_PACKET_BYTES
) (
  input  wire           clk,
  input  wire           rst,
  tsdesc_in_if.sink     stream,
  tsdesc_out_if.source  result,
  tsdesc_cfg_if.sink    regs
);
  import tsdesc_pkg::*;

  localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);
  localparam logic [8:0] PKT_LEN  = 9'(PACKET_BYTES);

  // key registers
  logic [63:0] even_key_high, even_key_low, odd_key_high, odd_key_low;

  // packet tracking
  state_t      state, state_next;
  logic [7:0]  byte_position;
  logic        scrambled_flag, odd_key_selected, adaptation_present;
  logic [8:0]  payload_offset;
  logic [3:0]  buffered_count;

  // round unit
  logic [127:0] blk;        // block buffer, then cipher state
  logic [127:0] rk;         // current round key
  logic [3:0]   rnd;        // expansion step, then round number
  logic [3:0]   emit_idx;
  logic         blk_pend;   // block ends the packet

  // clear-byte output register
  logic         pass_valid;
  logic [7:0]   pass_byte;
  logic         pass_end;

  // per-request decode
  logic         accept;
  logic [7:0]   p;
  logic [3:0]   cnt;
  logic         scr_next, odd_next, adp_next;
  logic [8:0]   po_next;
  logic [8:0]   span;
  logic         in_block;
  logic [7:0]   ob;
  logic         emitting;

  assign regs.ready   = 1'b1;
  assign emitting     = (state == ST_EMIT);
  assign stream.ready = (state == ST_IDLE) && (!pass_valid || result.ready);
  assign accept       = stream.valid && stream.ready;

  always_comb begin
    p        = stream.packet_start ? 8'd0 : byte_position;
    cnt      = stream.packet_start ? 4'd0 : buffered_count;
    scr_next = scrambled_flag;
    odd_next = odd_key_selected;
    adp_next = adaptation_present;
    po_next  = payload_offset;
    ob       = stream.packet_byte;
    if (p == 8'd3) begin
      scr_next = stream.packet_byte[7];
      odd_next = (stream.packet_byte & 8'hc0) == 8'hc0;
      adp_next = stream.packet_byte[5];
      po_next  = 9'd4;
      if (stream.packet_byte[7]) ob = stream.packet_byte & 8'h3f;
    end else if (p == 8'd4 && adaptation_present) begin
      po_next = 9'd5 + {1'b0, stream.packet_byte};
    end
    // bytes covered by whole blocks after the offset
    span     = (PKT_LEN - po_next) & 9'h1f0;
    in_block = scr_next && (p >= 8'd4) && ({1'b0, p} >= po_next) && (po_next <= PKT_LEN)
               && (({1'b0, p} - po_next) < span);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && in_block && cnt == 4'd15) state_next = ST_EXPAND;
      ST_EXPAND: if (rnd == 4'd10) state_next = ST_ROUND;
      ST_ROUND:  if (rnd == 4'd0) state_next = ST_EMIT;
      ST_EMIT:   if (result.ready && emit_idx == 4'd15) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // key writes
  always_ff @(posedge clk) begin
    if (rst) begin
      even_key_high <= '0;
      even_key_low  <= '0;
      odd_key_high  <= '0;
      odd_key_low   <= '0;
    end else if (regs.valid) begin
      case (regs.index)
        REG_EVEN_KEY_HIGH: even_key_high <= regs.data;
        REG_EVEN_KEY_LOW:  even_key_low  <= regs.data;
        REG_ODD_KEY_HIGH:  odd_key_high  <= regs.data;
        REG_ODD_KEY_LOW:   odd_key_low   <= regs.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // packet tracking and clear path
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      scrambled_flag     <= 1'b0;
      odd_key_selected   <= 1'b0;
      adaptation_present <= 1'b0;
      payload_offset     <= 9'd4;
      buffered_count     <= '0;
      pass_valid         <= 1'b0;
    end else begin
      if (pass_valid && result.ready) pass_valid <= 1'b0;
      if (accept) begin
        scrambled_flag     <= scr_next;
        odd_key_selected   <= odd_next;
        adaptation_present <= adp_next;
        payload_offset     <= po_next;
        byte_position      <= (p == LAST_POS) ? 8'd0 : p + 8'd1;
        if (in_block) begin
          buffered_count <= cnt + 4'd1;   // wraps to 0 on the sixteenth byte
        end else begin
          buffered_count <= cnt;
          pass_valid     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_block) begin
      pass_byte <= ob;
      pass_end  <= (p == LAST_POS);
    end
  end

  // round unit datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && in_block) begin
          blk[{4'd15 - cnt, 3'b000} +: 8] <= stream.packet_byte;
          if (cnt == 4'd15) begin
            rk       <= odd_next ? {odd_key_high, odd_key_low} : {even_key_high, even_key_low};
            rnd      <= 4'd1;
            blk_pend <= (p == LAST_POS);
          end
        end
      end
      ST_EXPAND: begin
        rk <= key_fwd(rk, rcon_of(rnd));
        if (rnd != 4'd10) rnd <= rnd + 4'd1;
      end
      ST_ROUND: begin
        if (rnd == 4'd10) blk <= blk ^ rk;
        else if (rnd == 4'd0) blk <= inv_shift_sub(blk) ^ rk;
        else blk <= inv_mix(inv_shift_sub(blk) ^ rk);
        rk <= key_back(rk, rcon_of(rnd));
        if (rnd == 4'd0) emit_idx <= 4'd0;
        else rnd <= rnd - 4'd1;
      end
      ST_EMIT: begin
        if (result.ready) emit_idx <= emit_idx + 4'd1;
      end
      default: ;
    endcase
  end

  assign result.valid      = emitting || pass_valid;
  assign result.out_byte   = emitting ? blk[{4'd15 - emit_idx, 3'b000} +: 8] : pass_byte;
  assign result.packet_end = emitting ? (emit_idx == 4'd15 && blk_pend) : pass_end;
  assign result.run_last   = emitting ? (emit_idx == 4'd15) : 1'b1;

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !stream.ready)
    else $error("request taken while round unit busy");

  a_no_pass_in_emit: assert property (@(posedge clk) disable iff (rst)
    emitting |-> !pass_valid)
    else $error("clear byte pending during block output");

  a_block_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPAND && $past(state) == ST_IDLE) |-> (rnd == 4'd1 && buffered_count == 4'd0))
    else $error("block started with bad counters");

  a_round_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && $past(state) == ST_EXPAND) |-> (rnd == 4'd10))
    else $error("rounds entered before key expansion finished");

endmodule

`default_nettype wire
